// ----- rtl/lfu_pkg.sv -----
// Shared constants, types and command/status structs for the LFU cache policy unit.
package lfu_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W      = IDX_W;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int LEAVES      = 1 << IDX_W;
  localparam int VKEY_W      = 1 + COUNT_WIDTH + RANK_W;

  localparam logic [CAP_W-1:0]       CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [DATA_W-1:0]      MISS_VALUE = {DATA_W{1'b1}};

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_TOUCH,
    ACT_EVICT,
    ACT_FILL
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_get;
  } dp_status_t;

endpackage

// ----- rtl/lfu_ctrl.sv -----
// Controller state machine: sequences lookup, write-back and result delivery.
module lfu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lfu_pkg::dp_status_t status,
  output lfu_pkg::ctrl_cmd_t  cmd
);

  lfu_pkg::state_t state;
  lfu_pkg::state_t state_next;
  logic            can_finish;

  // Write-back may proceed unless a get result would overwrite a held one
  assign can_finish = !status.is_get || !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        if (in_valid) state_next = lfu_pkg::ST_UPDATE;
      end
      lfu_pkg::ST_UPDATE: begin
        if (can_finish) state_next = lfu_pkg::ST_IDLE;
      end
      default: state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      lfu_pkg::ST_UPDATE: begin
        cmd.commit   = can_finish;
        cmd.load_out = can_finish && status.is_get;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Track the output register: set on load, drop once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/lfu_datapath.sv -----
// Datapath: entry table, key match, victim tree, write-back and result register.
module lfu_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  lfu_pkg::ctrl_cmd_t                 cmd,
  output lfu_pkg::dp_status_t                status,
  input  logic                               cfg_wr_en,
  input  logic        [lfu_pkg::CAP_W-1:0]   cfg_wr_data,
  input  logic                               command,
  input  logic signed [lfu_pkg::KEY_W-1:0]   key,
  input  logic signed [lfu_pkg::DATA_W-1:0]  value,
  output logic                               hit,
  output logic signed [lfu_pkg::DATA_W-1:0]  read_value
);

  // Configuration and table state
  logic [lfu_pkg::CAP_W-1:0]       capacity;
  logic [lfu_pkg::MAX_ENTRIES-1:0] entry_valid;
  logic [lfu_pkg::KEY_W-1:0]       entry_key   [lfu_pkg::MAX_ENTRIES];
  logic [lfu_pkg::DATA_W-1:0]      entry_value [lfu_pkg::MAX_ENTRIES];
  logic [lfu_pkg::COUNT_WIDTH-1:0] use_count   [lfu_pkg::MAX_ENTRIES];
  logic [lfu_pkg::RANK_W-1:0]      recency_rank[lfu_pkg::MAX_ENTRIES];
  logic [lfu_pkg::OCC_W-1:0]       occupied_count;

  // Captured request
  logic                          req_get;
  logic [lfu_pkg::KEY_W-1:0]     req_key;
  logic [lfu_pkg::DATA_W-1:0]    req_value;
  lfu_pkg::action_t              req_action;
  logic [lfu_pkg::IDX_W-1:0]     req_slot;

  // Lookup cycle signals
  logic [lfu_pkg::MAX_ENTRIES-1:0] match;
  logic                            match_any;
  logic [lfu_pkg::IDX_W-1:0]       match_idx;
  logic                            free_found;
  logic [lfu_pkg::IDX_W-1:0]       free_idx;
  logic [lfu_pkg::OCC_W-1:0]       cap_eff;
  lfu_pkg::action_t                action;
  logic [lfu_pkg::IDX_W-1:0]       slot;
  logic [lfu_pkg::VKEY_W-1:0]      node_key[2*lfu_pkg::LEAVES];
  logic [lfu_pkg::IDX_W-1:0]       node_idx[2*lfu_pkg::LEAVES];
  logic [lfu_pkg::IDX_W-1:0]       victim_idx;

  // Write-back cycle signals
  logic                            do_unlink;
  logic [lfu_pkg::RANK_W-1:0]      sel_rank;
  logic [lfu_pkg::RANK_W-1:0]      new_rank;
  logic [lfu_pkg::COUNT_WIDTH-1:0] sel_count;

  assign status.is_get = req_get;

  // Match the incoming key against every valid entry
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == key);
      if (match[i]) match_idx = match_idx | lfu_pkg::IDX_W'(i);
    end
    match_any = |match;
  end

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
      if (!entry_valid[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = lfu_pkg::IDX_W'(i);
      end
    end
  end

  // Victim: minimum of {invalid, count, rank} through a binary tree
  always_comb begin
    for (int i = 0; i < lfu_pkg::LEAVES; i++) begin
      node_idx[lfu_pkg::LEAVES + i] = lfu_pkg::IDX_W'(i);
      if (i < lfu_pkg::MAX_ENTRIES) begin
        node_key[lfu_pkg::LEAVES + i] = {!entry_valid[i], use_count[i], recency_rank[i]};
      end else begin
        node_key[lfu_pkg::LEAVES + i] = '1;
      end
    end
    node_key[0] = '1;
    node_idx[0] = '0;
    for (int n = lfu_pkg::LEAVES - 1; n >= 1; n--) begin
      if (node_key[2*n+1] < node_key[2*n]) begin
        node_key[n] = node_key[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end else begin
        node_key[n] = node_key[2*n];
        node_idx[n] = node_idx[2*n];
      end
    end
    victim_idx = node_idx[1];
  end

  // Decide what the request does to the table
  always_comb begin
    if (32'(capacity) > 32'(lfu_pkg::MAX_ENTRIES)) begin
      cap_eff = lfu_pkg::OCC_W'(lfu_pkg::MAX_ENTRIES);
    end else begin
      cap_eff = lfu_pkg::OCC_W'(capacity);
    end
    action = lfu_pkg::ACT_NONE;
    slot   = match_idx;
    if (match_any) begin
      action = lfu_pkg::ACT_TOUCH;
    end else if (command == lfu_pkg::CMD_PUT && cap_eff != '0) begin
      if (occupied_count >= cap_eff) begin
        action = lfu_pkg::ACT_EVICT;
        slot   = victim_idx;
      end else begin
        action = lfu_pkg::ACT_FILL;
        slot   = free_idx;
      end
    end
  end

  // Capture the request with its lookup outcome
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_get    <= (command == lfu_pkg::CMD_GET);
      req_key    <= key;
      req_value  <= value;
      req_action <= action;
      req_slot   <= slot;
    end
  end

  // Write-back values for the selected slot
  always_comb begin
    sel_rank  = recency_rank[req_slot];
    sel_count = use_count[req_slot];
    do_unlink = (req_action == lfu_pkg::ACT_TOUCH) || (req_action == lfu_pkg::ACT_EVICT);
    if (req_action == lfu_pkg::ACT_FILL) begin
      new_rank = lfu_pkg::RANK_W'(occupied_count);
    end else begin
      new_rank = lfu_pkg::RANK_W'(occupied_count - lfu_pkg::OCC_W'(1));
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfu_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= '0;
      occupied_count <= '0;
    end else if (cmd.commit && req_action == lfu_pkg::ACT_FILL) begin
      entry_valid[req_slot] <= 1'b1;
      occupied_count        <= occupied_count + lfu_pkg::OCC_W'(1);
    end
  end

  // Entry payload, counts and recency ranks
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
        if (lfu_pkg::IDX_W'(i) == req_slot) begin
          case (req_action) inside
            lfu_pkg::ACT_TOUCH: begin
              if (sel_count != lfu_pkg::COUNT_MAX) begin
                use_count[i] <= sel_count + lfu_pkg::COUNT_WIDTH'(1);
              end
              if (!req_get) entry_value[i] <= req_value;
              recency_rank[i] <= new_rank;
            end
            lfu_pkg::ACT_EVICT, lfu_pkg::ACT_FILL: begin
              entry_key[i]    <= req_key;
              entry_value[i]  <= req_value;
              use_count[i]    <= lfu_pkg::COUNT_WIDTH'(1);
              recency_rank[i] <= new_rank;
            end
            default: begin
            end
          endcase
        end else if (do_unlink && entry_valid[i] && recency_rank[i] > sel_rank) begin
          // Close the gap left by the touched or evicted entry
          recency_rank[i] <= recency_rank[i] - lfu_pkg::RANK_W'(1);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit <= (req_action == lfu_pkg::ACT_TOUCH);
      if (req_action == lfu_pkg::ACT_TOUCH) begin
        read_value <= entry_value[req_slot];
      end else begin
        read_value <= lfu_pkg::MISS_VALUE;
      end
    end
  end

endmodule

// ----- rtl/lfu_cache_policy_unit.sv -----
// A get result is loaded into the output register when its write-back completes
// and can be taken from the following cycle on.
// Each transaction has a lookup step (key match and victim tree over all entries)
// and a write-back step for counts, ranks and payload; no new one is accepted during write-back.
// A held get result stalls only the write-back of the next get.
// Reset empties the table, clears occupancy and sets capacity to 16.
module lfu_cache_policy_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic        [lfu_pkg::CAP_W-1:0]   cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic signed [lfu_pkg::KEY_W-1:0]   key,
  input  logic signed [lfu_pkg::DATA_W-1:0]  value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic signed [lfu_pkg::DATA_W-1:0]  read_value
);

  lfu_pkg::ctrl_cmd_t  cmd;
  lfu_pkg::dp_status_t status;

  // Controller
  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath
  lfu_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .command     (command),
    .key         (key),
    .value       (value),
    .hit         (hit),
    .read_value  (read_value)
  );

endmodule
